// ===== rtl/ucd_pkg.sv =====
// shared types and constants for the undirected cycle detector
package ucd_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_DEGREE   = 16;

  localparam int VTX_W = 6;
  localparam int CNT_W = 7;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_DEGREE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ADD_F,
    S_ADD_T,
    S_ADD_D,
    S_CLR,
    S_VCLR,
    S_OUTER,
    S_OUTER_V,
    S_TOP_DEG,
    S_STEP,
    S_POP,
    S_NB,
    S_NB_PAR,
    S_NB_VIS,
    S_DONE
  } state_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  typedef struct packed {
    logic deg;
    logic nbr;
    logic vis;
    logic stk;
  } mem_we_t;

endpackage

// ===== rtl/ucd_cmp.sv =====
// shared magnitude and equality compare unit
module ucd_cmp #(
  parameter int W = 8
) (
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output ucd_pkg::cmp_res_t res
);

  assign res.lt = (a < b);
  assign res.eq = (a == b);

endmodule

// ===== rtl/ucd_store.sv =====
// neighbor, degree, visited and walk stack memories
module ucd_store #(
  parameter int MAX_VERTICES = ucd_pkg::DEF_MAX_VERTICES,
  parameter int MAX_DEGREE   = ucd_pkg::DEF_MAX_DEGREE
) (
  input  logic                    clk,
  input  ucd_pkg::mem_we_t        we,
  input  logic [$clog2(MAX_VERTICES)-1:0] deg_raddr,
  input  logic [$clog2(MAX_VERTICES)-1:0] deg_waddr,
  input  logic [$clog2(MAX_DEGREE+1)-1:0] deg_wdata,
  output logic [$clog2(MAX_DEGREE+1)-1:0] deg_rdata,
  input  logic [$clog2(MAX_VERTICES)+((MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1)-1:0] nbr_raddr,
  input  logic [$clog2(MAX_VERTICES)+((MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1)-1:0] nbr_waddr,
  input  logic [ucd_pkg::VTX_W-1:0] nbr_wdata,
  output logic [ucd_pkg::VTX_W-1:0] nbr_rdata,
  input  logic [$clog2(MAX_VERTICES)-1:0] vis_raddr,
  input  logic [$clog2(MAX_VERTICES)-1:0] vis_waddr,
  input  logic                    vis_wdata,
  output logic                    vis_rdata,
  input  logic [$clog2(MAX_VERTICES)-1:0] stk_raddr,
  input  logic [$clog2(MAX_VERTICES)-1:0] stk_waddr,
  input  logic [2*$clog2(MAX_VERTICES)+$clog2(MAX_DEGREE+1):0] stk_wdata,
  output logic [2*$clog2(MAX_VERTICES)+$clog2(MAX_DEGREE+1):0] stk_rdata
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int DCW = $clog2(MAX_DEGREE + 1);
  localparam int NIW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int FW  = 2 * VW + 1 + DCW;
  localparam int NBR_DEPTH = MAX_VERTICES * (1 << NIW);

  logic [DCW-1:0]            deg_mem [MAX_VERTICES];
  logic [ucd_pkg::VTX_W-1:0] nbr_mem [NBR_DEPTH];
  logic                      vis_mem [MAX_VERTICES];
  logic [FW-1:0]             stk_mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (we.deg) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_rdata <= deg_mem[deg_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.nbr) begin
      nbr_mem[nbr_waddr] <= nbr_wdata;
    end
    nbr_rdata <= nbr_mem[nbr_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.vis) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rdata <= vis_mem[vis_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.stk) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata <= stk_mem[stk_raddr];
  end

endmodule

// ===== rtl/ucd_seq.sv =====
// sequencer for loading, clearing and the depth-first cycle walk
module ucd_seq #(
  parameter int MAX_VERTICES = ucd_pkg::DEF_MAX_VERTICES,
  parameter int MAX_DEGREE   = ucd_pkg::DEF_MAX_DEGREE
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [15:0]             in_tdata,   // from_vertex, to_vertex
  input  logic [ucd_pkg::OP_W-1:0] in_tuser,  // opcode
  input  logic [ucd_pkg::CNT_W-1:0] count,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [ucd_pkg::ST_W-1:0] res_status,
  output logic                    res_cycle,
  output ucd_pkg::mem_we_t        we,
  output logic [$clog2(MAX_VERTICES)-1:0] deg_raddr,
  output logic [$clog2(MAX_VERTICES)-1:0] deg_waddr,
  output logic [$clog2(MAX_DEGREE+1)-1:0] deg_wdata,
  input  logic [$clog2(MAX_DEGREE+1)-1:0] deg_rdata,
  output logic [$clog2(MAX_VERTICES)+((MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1)-1:0] nbr_raddr,
  output logic [$clog2(MAX_VERTICES)+((MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1)-1:0] nbr_waddr,
  output logic [ucd_pkg::VTX_W-1:0] nbr_wdata,
  input  logic [ucd_pkg::VTX_W-1:0] nbr_rdata,
  output logic [$clog2(MAX_VERTICES)-1:0] vis_raddr,
  output logic [$clog2(MAX_VERTICES)-1:0] vis_waddr,
  output logic                    vis_wdata,
  input  logic                    vis_rdata,
  output logic [$clog2(MAX_VERTICES)-1:0] stk_raddr,
  output logic [$clog2(MAX_VERTICES)-1:0] stk_waddr,
  output logic [2*$clog2(MAX_VERTICES)+$clog2(MAX_DEGREE+1):0] stk_wdata,
  input  logic [2*$clog2(MAX_VERTICES)+$clog2(MAX_DEGREE+1):0] stk_rdata
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int DCW = $clog2(MAX_DEGREE + 1);
  localparam int NIW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DPW = $clog2(MAX_VERTICES + 1);
  localparam int CW  = ucd_pkg::CNT_W;
  localparam int UW0 = (CW > DCW) ? CW : DCW;
  localparam int UW  = (UW0 > VW) ? UW0 : VW;
  localparam logic [VW-1:0] SWEEP_LAST = VW'(MAX_VERTICES - 1);

  ucd_pkg::state_t state_r, state_nxt;

  logic [VW-1:0]             sweep_r, sweep_nxt;
  logic [DPW-1:0]            depth_r, depth_nxt;
  logic [CW-1:0]             i_r, i_nxt;
  logic [ucd_pkg::VTX_W-1:0] from_r, from_nxt;
  logic [ucd_pkg::VTX_W-1:0] to_r, to_nxt;
  logic [ucd_pkg::VTX_W-1:0] nb_r, nb_nxt;
  logic [VW-1:0]             top_v_r, top_v_nxt;
  logic [VW-1:0]             top_p_r, top_p_nxt;
  logic                      top_hp_r, top_hp_nxt;
  logic [DCW-1:0]            top_nx_r, top_nx_nxt;
  logic [DCW-1:0]            top_deg_r, top_deg_nxt;
  logic [ucd_pkg::ST_W-1:0]  status_r, status_nxt;
  logic                      cycle_r, cycle_nxt;

  logic [UW-1:0]     cmp_a;
  logic [UW-1:0]     cmp_b;
  ucd_pkg::cmp_res_t cmp;

  ucd_cmp #(.W(UW)) u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  assign res_status = status_r;
  assign res_cycle  = cycle_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ucd_pkg::S_INIT: begin
        if (sweep_r == SWEEP_LAST) state_nxt = ucd_pkg::S_IDLE;
      end
      ucd_pkg::S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            ucd_pkg::OP_ADD:   state_nxt = ucd_pkg::S_ADD_F;
            ucd_pkg::OP_CHECK: state_nxt = ucd_pkg::S_VCLR;
            ucd_pkg::OP_CLEAR: state_nxt = ucd_pkg::S_CLR;
            default:           state_nxt = ucd_pkg::S_DONE;
          endcase
        end
      end
      ucd_pkg::S_ADD_F: state_nxt = cmp.lt ? ucd_pkg::S_ADD_T : ucd_pkg::S_DONE;
      ucd_pkg::S_ADD_T: state_nxt = cmp.lt ? ucd_pkg::S_ADD_D : ucd_pkg::S_DONE;
      ucd_pkg::S_ADD_D: state_nxt = ucd_pkg::S_DONE;
      ucd_pkg::S_CLR: begin
        if (sweep_r == SWEEP_LAST) state_nxt = ucd_pkg::S_DONE;
      end
      ucd_pkg::S_VCLR: begin
        if (sweep_r == SWEEP_LAST) state_nxt = ucd_pkg::S_OUTER;
      end
      ucd_pkg::S_OUTER: state_nxt = cmp.lt ? ucd_pkg::S_OUTER_V : ucd_pkg::S_DONE;
      ucd_pkg::S_OUTER_V: state_nxt = vis_rdata ? ucd_pkg::S_OUTER : ucd_pkg::S_TOP_DEG;
      ucd_pkg::S_TOP_DEG: state_nxt = ucd_pkg::S_STEP;
      ucd_pkg::S_STEP: begin
        if (cmp.lt) state_nxt = ucd_pkg::S_NB;
        else if (depth_r == DPW'(1)) state_nxt = ucd_pkg::S_OUTER;
        else state_nxt = ucd_pkg::S_POP;
      end
      ucd_pkg::S_POP: state_nxt = ucd_pkg::S_TOP_DEG;
      ucd_pkg::S_NB: state_nxt = cmp.lt ? ucd_pkg::S_NB_PAR : ucd_pkg::S_STEP;
      ucd_pkg::S_NB_PAR: begin
        if (top_hp_r && cmp.eq) state_nxt = ucd_pkg::S_STEP;
        else state_nxt = ucd_pkg::S_NB_VIS;
      end
      ucd_pkg::S_NB_VIS: state_nxt = vis_rdata ? ucd_pkg::S_DONE : ucd_pkg::S_TOP_DEG;
      ucd_pkg::S_DONE: begin
        if (res_ready) state_nxt = ucd_pkg::S_IDLE;
      end
      default: state_nxt = ucd_pkg::S_INIT;
    endcase
  end

  // datapath controls and register updates
  always_comb begin
    in_tready   = 1'b0;
    res_valid   = 1'b0;
    we          = '0;
    deg_raddr   = '0;
    deg_waddr   = '0;
    deg_wdata   = '0;
    nbr_raddr   = '0;
    nbr_waddr   = '0;
    nbr_wdata   = '0;
    vis_raddr   = '0;
    vis_waddr   = '0;
    vis_wdata   = 1'b0;
    stk_raddr   = '0;
    stk_waddr   = '0;
    stk_wdata   = '0;
    cmp_a       = '0;
    cmp_b       = '0;
    sweep_nxt   = sweep_r;
    depth_nxt   = depth_r;
    i_nxt       = i_r;
    from_nxt    = from_r;
    to_nxt      = to_r;
    nb_nxt      = nb_r;
    top_v_nxt   = top_v_r;
    top_p_nxt   = top_p_r;
    top_hp_nxt  = top_hp_r;
    top_nx_nxt  = top_nx_r;
    top_deg_nxt = top_deg_r;
    status_nxt  = status_r;
    cycle_nxt   = cycle_r;
    case (state_r)
      ucd_pkg::S_INIT, ucd_pkg::S_CLR: begin
        we.deg    = 1'b1;
        deg_waddr = sweep_r;
        sweep_nxt = sweep_r + VW'(1);
      end
      ucd_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        from_nxt   = in_tdata[5:0];
        to_nxt     = in_tdata[11:6];
        sweep_nxt  = '0;
        depth_nxt  = '0;
        status_nxt = ucd_pkg::ST_OK;
        cycle_nxt  = 1'b0;
      end
      ucd_pkg::S_ADD_F: begin
        cmp_a = UW'(from_r);
        cmp_b = UW'(count);
        if (!cmp.lt) status_nxt = ucd_pkg::ST_RANGE;
      end
      ucd_pkg::S_ADD_T: begin
        cmp_a     = UW'(to_r);
        cmp_b     = UW'(count);
        deg_raddr = VW'(from_r);
        if (!cmp.lt) status_nxt = ucd_pkg::ST_RANGE;
      end
      ucd_pkg::S_ADD_D: begin
        cmp_a = UW'(deg_rdata);
        cmp_b = UW'(MAX_DEGREE);
        if (!cmp.lt) begin
          status_nxt = ucd_pkg::ST_DEGREE;
        end else begin
          we.nbr    = 1'b1;
          nbr_waddr = {VW'(from_r), deg_rdata[NIW-1:0]};
          nbr_wdata = to_r;
          we.deg    = 1'b1;
          deg_waddr = VW'(from_r);
          deg_wdata = deg_rdata + DCW'(1);
        end
      end
      ucd_pkg::S_VCLR: begin
        we.vis    = 1'b1;
        vis_waddr = sweep_r;
        sweep_nxt = sweep_r + VW'(1);
        i_nxt     = '0;
      end
      ucd_pkg::S_OUTER: begin
        cmp_a     = UW'(i_r);
        cmp_b     = UW'(count);
        vis_raddr = VW'(i_r);
      end
      ucd_pkg::S_OUTER_V: begin
        if (vis_rdata) begin
          i_nxt = i_r + CW'(1);
        end else begin
          top_v_nxt  = VW'(i_r);
          top_p_nxt  = '0;
          top_hp_nxt = 1'b0;
          top_nx_nxt = '0;
          depth_nxt  = DPW'(1);
          we.vis     = 1'b1;
          vis_waddr  = VW'(i_r);
          vis_wdata  = 1'b1;
          deg_raddr  = VW'(i_r);
        end
      end
      ucd_pkg::S_TOP_DEG: begin
        top_deg_nxt = deg_rdata;
      end
      ucd_pkg::S_STEP: begin
        cmp_a = UW'(top_nx_r);
        cmp_b = UW'(top_deg_r);
        if (cmp.lt) begin
          nbr_raddr  = {top_v_r, top_nx_r[NIW-1:0]};
          top_nx_nxt = top_nx_r + DCW'(1);
        end else begin
          depth_nxt = depth_r - DPW'(1);
          stk_raddr = VW'(depth_r - DPW'(2));
          if (depth_r == DPW'(1)) i_nxt = i_r + CW'(1);
        end
      end
      ucd_pkg::S_POP: begin
        {top_v_nxt, top_p_nxt, top_hp_nxt, top_nx_nxt} = stk_rdata;
        deg_raddr = stk_rdata[2*VW+DCW -: VW];
      end
      ucd_pkg::S_NB: begin
        cmp_a  = UW'(nbr_rdata);
        cmp_b  = UW'(count);
        nb_nxt = nbr_rdata;
      end
      ucd_pkg::S_NB_PAR: begin
        cmp_a     = UW'(nb_r);
        cmp_b     = UW'(top_p_r);
        vis_raddr = VW'(nb_r);
      end
      ucd_pkg::S_NB_VIS: begin
        if (vis_rdata) begin
          cycle_nxt = 1'b1;
        end else begin
          we.stk     = 1'b1;
          stk_waddr  = VW'(depth_r - DPW'(1));
          stk_wdata  = {top_v_r, top_p_r, top_hp_r, top_nx_r};
          top_v_nxt  = VW'(nb_r);
          top_p_nxt  = top_v_r;
          top_hp_nxt = 1'b1;
          top_nx_nxt = '0;
          depth_nxt  = depth_r + DPW'(1);
          we.vis     = 1'b1;
          vis_waddr  = VW'(nb_r);
          vis_wdata  = 1'b1;
          deg_raddr  = VW'(nb_r);
        end
      end
      ucd_pkg::S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        sweep_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ucd_pkg::S_INIT;
      sweep_r <= '0;
      depth_r <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    from_r    <= from_nxt;
    to_r      <= to_nxt;
    nb_r      <= nb_nxt;
    top_v_r   <= top_v_nxt;
    top_p_r   <= top_p_nxt;
    top_hp_r  <= top_hp_nxt;
    top_nx_r  <= top_nx_nxt;
    top_deg_r <= top_deg_nxt;
    status_r  <= status_nxt;
    cycle_r   <= cycle_nxt;
  end

endmodule

// ===== rtl/undirected_cycle_detect_dfs.sv =====
// top level of the undirected graph cycle detector
//
// Adjacency entries are loaded one beat at a time into per-vertex neighbor lists, a check beat
// runs a depth-first walk over the vertices in use and reports whether any cycle exists, and a
// clear beat empties all lists. One item is handled at a time and in_tready is low while it is
// worked on; the finished result waits in an output register, so the next item is taken even if
// out_tready is low. An add checks the from and the to vertex against vertex_count and then the
// degree of the from vertex before it stores the entry, a clear walks every degree entry, and a
// check first clears the visited marks and then walks the vertices in use and their stored
// neighbor entries, backtracking when a vertex has none left; every sequencer step uses the
// single shared compare unit at most once, and each memory read is registered. After reset the
// degree memory is cleared in a pass over all MAX_VERTICES entries during which no item is
// taken. vertex_count is written through cfg_tdata; the user must write it only while no item
// is in flight; the block does not enforce it. Counts above MAX_VERTICES act as MAX_VERTICES.
module undirected_cycle_detect_dfs #(
  parameter int MAX_VERTICES = ucd_pkg::DEF_MAX_VERTICES,
  parameter int MAX_DEGREE   = ucd_pkg::DEF_MAX_DEGREE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata,   // vertex_count [6:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // from_vertex [5:0], to_vertex [11:6]
  input  logic [1:0]  in_tuser,    // opcode [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata    // status [1:0], cycle_found [2]
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int DCW = $clog2(MAX_DEGREE + 1);
  localparam int NIW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int FW  = 2 * VW + 1 + DCW;
  localparam int CW  = ucd_pkg::CNT_W;
  localparam int CAP = (MAX_VERTICES > 127) ? 127 : MAX_VERTICES;

  logic [CW-1:0] cfg_r;
  logic [CW-1:0] count;

  logic                      res_valid;
  logic                      res_ready;
  logic [ucd_pkg::ST_W-1:0]  res_status;
  logic                      res_cycle;
  logic                      out_valid_r;
  logic [ucd_pkg::ST_W-1:0]  out_status_r;
  logic                      out_cycle_r;

  ucd_pkg::mem_we_t          we;
  logic [VW-1:0]             deg_raddr;
  logic [VW-1:0]             deg_waddr;
  logic [DCW-1:0]            deg_wdata;
  logic [DCW-1:0]            deg_rdata;
  logic [VW+NIW-1:0]         nbr_raddr;
  logic [VW+NIW-1:0]         nbr_waddr;
  logic [ucd_pkg::VTX_W-1:0] nbr_wdata;
  logic [ucd_pkg::VTX_W-1:0] nbr_rdata;
  logic [VW-1:0]             vis_raddr;
  logic [VW-1:0]             vis_waddr;
  logic                      vis_wdata;
  logic                      vis_rdata;
  logic [VW-1:0]             stk_raddr;
  logic [VW-1:0]             stk_waddr;
  logic [FW-1:0]             stk_wdata;
  logic [FW-1:0]             stk_rdata;

  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ucd_pkg::CNT_RESET;
    end else if (cfg_tvalid) begin
      cfg_r <= cfg_tdata[CW-1:0];
    end
  end

  assign count = (cfg_r > CW'(CAP)) ? CW'(CAP) : cfg_r;

  ucd_seq #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .count      (count),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status),
    .res_cycle  (res_cycle),
    .we         (we),
    .deg_raddr  (deg_raddr),
    .deg_waddr  (deg_waddr),
    .deg_wdata  (deg_wdata),
    .deg_rdata  (deg_rdata),
    .nbr_raddr  (nbr_raddr),
    .nbr_waddr  (nbr_waddr),
    .nbr_wdata  (nbr_wdata),
    .nbr_rdata  (nbr_rdata),
    .vis_raddr  (vis_raddr),
    .vis_waddr  (vis_waddr),
    .vis_wdata  (vis_wdata),
    .vis_rdata  (vis_rdata),
    .stk_raddr  (stk_raddr),
    .stk_waddr  (stk_waddr),
    .stk_wdata  (stk_wdata),
    .stk_rdata  (stk_rdata)
  );

  ucd_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_store (
    .clk       (clk),
    .we        (we),
    .deg_raddr (deg_raddr),
    .deg_waddr (deg_waddr),
    .deg_wdata (deg_wdata),
    .deg_rdata (deg_rdata),
    .nbr_raddr (nbr_raddr),
    .nbr_waddr (nbr_waddr),
    .nbr_wdata (nbr_wdata),
    .nbr_rdata (nbr_rdata),
    .vis_raddr (vis_raddr),
    .vis_waddr (vis_waddr),
    .vis_wdata (vis_wdata),
    .vis_rdata (vis_rdata),
    .stk_raddr (stk_raddr),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_rdata (stk_rdata)
  );

  // result register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res_status;
      out_cycle_r  <= res_cycle;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cycle_r, out_status_r};

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in progress");

  a_cycle_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[2] || (out_tdata[1:0] == ucd_pkg::ST_OK)))
    else $error("cycle flag set on a refused entry");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3))
    else $error("unknown status code");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> res_valid)
    else $error("finished result dropped while output busy");

endmodule

// ===== dv/tb_undirected_cycle_detect_dfs.sv =====
// testbench for the undirected cycle detector with directed and random beats
module tb_undirected_cycle_detect_dfs;

  typedef struct {
    logic [ucd_pkg::ST_W-1:0] status;
    logic                     cycle;
  } verdict_t;

  class cycle_scoreboard;
    logic [ucd_pkg::CNT_W-1:0] vertex_count;
    int unsigned               degree [ucd_pkg::DEF_MAX_VERTICES];
    logic [ucd_pkg::VTX_W-1:0] adjacency [ucd_pkg::DEF_MAX_VERTICES][ucd_pkg::DEF_MAX_DEGREE];
    verdict_t                  awaited_verdicts [$];
    int                        errors;

    function new();
      vertex_count = ucd_pkg::CNT_RESET;
      foreach (degree[i]) degree[i] = 0;
      errors = 0;
    endfunction

    function int vertices_in_use();
      return (vertex_count > ucd_pkg::DEF_MAX_VERTICES) ? ucd_pkg::DEF_MAX_VERTICES :
             int'(vertex_count);
    endfunction

    // explicit-stack depth-first walk over every vertex in use
    function logic graph_has_cycle();
      int n;
      int sp;
      int v;
      int nb;
      logic [ucd_pkg::DEF_MAX_VERTICES-1:0] seen;
      int frame_vtx [ucd_pkg::DEF_MAX_VERTICES];
      int frame_par [ucd_pkg::DEF_MAX_VERTICES];
      int frame_idx [ucd_pkg::DEF_MAX_VERTICES];
      logic frame_has_par [ucd_pkg::DEF_MAX_VERTICES];
      n = vertices_in_use();
      seen = '0;
      for (int root = 0; root < n; root++) begin
        if (seen[root]) continue;
        sp = 1;
        frame_vtx[0] = root;
        frame_par[0] = 0;
        frame_has_par[0] = 1'b0;
        frame_idx[0] = 0;
        seen[root] = 1'b1;
        while (sp > 0) begin
          v = frame_vtx[sp-1];
          if (frame_idx[sp-1] >= degree[v]) begin
            sp--;
            continue;
          end
          nb = int'(adjacency[v][frame_idx[sp-1]]);
          frame_idx[sp-1]++;
          if (nb >= n) continue;
          if (frame_has_par[sp-1] && nb == frame_par[sp-1]) continue;
          if (seen[nb]) return 1'b1;
          frame_vtx[sp] = nb;
          frame_par[sp] = v;
          frame_has_par[sp] = 1'b1;
          frame_idx[sp] = 0;
          seen[nb] = 1'b1;
          sp++;
        end
      end
      return 1'b0;
    endfunction

    function void note_item(logic [ucd_pkg::OP_W-1:0] op, logic [ucd_pkg::VTX_W-1:0] fv,
                            logic [ucd_pkg::VTX_W-1:0] tv);
      verdict_t r;
      int n;
      n = vertices_in_use();
      r.status = ucd_pkg::ST_OK;
      r.cycle = 1'b0;
      case (op)
        ucd_pkg::OP_ADD: begin
          if (fv >= n || tv >= n) begin
            r.status = ucd_pkg::ST_RANGE;
          end else if (degree[fv] >= ucd_pkg::DEF_MAX_DEGREE) begin
            r.status = ucd_pkg::ST_DEGREE;
          end else begin
            adjacency[fv][degree[fv]] = tv;
            degree[fv]++;
          end
        end
        ucd_pkg::OP_CHECK: r.cycle = graph_has_cycle();
        ucd_pkg::OP_CLEAR: foreach (degree[i]) degree[i] = 0;
        default: ;
      endcase
      awaited_verdicts = {awaited_verdicts, r};
    endfunction

    function void check_result(logic [7:0] beat);
      verdict_t want;
      if (awaited_verdicts.size() == 0) begin
        $display("%0t: result beat with nothing expected: expected none, actual %h",
                 $time, beat);
        errors++;
        return;
      end
      want = awaited_verdicts.pop_front();
      if (beat[1:0] !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status,
                 beat[1:0]);
        errors++;
      end
      if (beat[2] !== want.cycle) begin
        $display("%0t: cycle_found mismatch: expected %0d, actual %0d", $time, want.cycle,
                 beat[2]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [7:0]  cfg_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // from_vertex [5:0], to_vertex [11:6]
  logic [1:0]  in_tuser;   // opcode [1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // status [1:0], cycle_found [2]

  cycle_scoreboard board = new();
  int accepted_items = 0;
  bit source_quiet = 1'b0;
  bit sink_quiet = 1'b0;
  bit hold_output = 1'b0;

  undirected_cycle_detect_dfs u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  initial begin
    #200000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic offer_item(input logic [ucd_pkg::OP_W-1:0] op, input int fv, input int tv);
    int gap;
    gap = source_quiet ? 0 : int'($urandom_range(0, 15));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0, tv[ucd_pkg::VTX_W-1:0], fv[ucd_pkg::VTX_W-1:0]};
    do @(posedge clk); while (!in_tready);
    board.note_item(op, fv[ucd_pkg::VTX_W-1:0], tv[ucd_pkg::VTX_W-1:0]);
    if (op != ucd_pkg::OP_NOP) accepted_items++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.awaited_verdicts.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [ucd_pkg::CNT_W-1:0] value);
    drain_results();
    cfg_tvalid <= 1'b1;
    cfg_tdata <= {1'b0, value};
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
    board.vertex_count = value;
  endtask

  task automatic add_edge(input int a, input int b);
    if ($urandom_range(0, 9) == 0) begin
      offer_item(ucd_pkg::OP_ADD, a, b);
    end else if ($urandom_range(0, 1)) begin
      offer_item(ucd_pkg::OP_ADD, a, b);
      offer_item(ucd_pkg::OP_ADD, b, a);
    end else begin
      offer_item(ucd_pkg::OP_ADD, b, a);
      offer_item(ucd_pkg::OP_ADD, a, b);
    end
  endtask

  // optional clear, then a forest on random vertices, sometimes with one extra edge, then a check
  task automatic grow_forest(input int n);
    int order [ucd_pkg::DEF_MAX_VERTICES];
    int k;
    int j;
    int tmp;
    if ($urandom_range(0, 3) != 0)
      offer_item(ucd_pkg::OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
    if (n > 0) begin
      for (int i = 0; i < n; i++) order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      k = ($urandom_range(0, 9) == 0) ? n : $urandom_range(1, (n < 8) ? n : 8);
      for (int i = 1; i < k; i++) begin
        if ($urandom_range(0, 4) != 0) add_edge(order[i], order[$urandom_range(0, i - 1)]);
      end
      if ($urandom_range(0, 1))
        add_edge(order[$urandom_range(0, k - 1)], order[$urandom_range(0, k - 1)]);
    end
    offer_item(ucd_pkg::OP_CHECK, $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  task automatic overflow_degree(input int n);
    int v;
    v = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
    repeat (ucd_pkg::DEF_MAX_DEGREE + $urandom_range(1, 3))
      offer_item(ucd_pkg::OP_ADD, v, (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63));
    offer_item(ucd_pkg::OP_CHECK, $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  task automatic random_noise();
    repeat ($urandom_range(3, 10)) begin
      case ($urandom_range(0, 9))
        0: offer_item(ucd_pkg::OP_CHECK, $urandom_range(0, 63), $urandom_range(0, 63));
        1: offer_item(ucd_pkg::OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
        2: offer_item(ucd_pkg::OP_NOP, $urandom_range(0, 63), $urandom_range(0, 63));
        default: offer_item(ucd_pkg::OP_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
      endcase
    end
  endtask

  initial begin : result_sink
    int wait_cycles;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_output) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_output = 1'b0;
      end
      wait_cycles = sink_quiet ? 0 : int'($urandom_range(0, 15));
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      board.check_result(out_tdata);
      if ($urandom_range(0, 19) == 0) sink_quiet = !sink_quiet;
    end
  end

  initial begin : stimulus
    int schedule [9] = '{127, 0, 1, 2, 64, 3, 40, 63, 10};
    int phase;
    int n;
    logic [ucd_pkg::CNT_W-1:0] setting;
    rst_n <= 1'b0;
    cfg_tvalid <= 1'b0;
    cfg_tdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats at the reset vertex count
    offer_item(ucd_pkg::OP_CHECK, 0, 0);
    offer_item(ucd_pkg::OP_ADD, 0, 1);
    offer_item(ucd_pkg::OP_ADD, 1, 0);
    offer_item(ucd_pkg::OP_CHECK, 0, 0);
    offer_item(ucd_pkg::OP_ADD, 63, 63);
    offer_item(ucd_pkg::OP_CHECK, 63, 63);
    offer_item(ucd_pkg::OP_CLEAR, 0, 0);
    offer_item(ucd_pkg::OP_CHECK, 0, 0);
    offer_item(ucd_pkg::OP_ADD, 0, 1);
    offer_item(ucd_pkg::OP_ADD, 1, 2);
    offer_item(ucd_pkg::OP_ADD, 2, 0);
    offer_item(ucd_pkg::OP_CHECK, 0, 0);
    offer_item(ucd_pkg::OP_NOP, 63, 63);
    offer_item(ucd_pkg::OP_CLEAR, 63, 63);
    offer_item(ucd_pkg::OP_ADD, 0, 63);
    offer_item(ucd_pkg::OP_ADD, 63, 0);
    offer_item(ucd_pkg::OP_CHECK, 0, 0);
    offer_item(ucd_pkg::OP_CLEAR, 0, 0);

    phase = 0;
    while (accepted_items < 650) begin
      setting = (phase < 9) ? (ucd_pkg::CNT_W)'(schedule[phase]) :
                (ucd_pkg::CNT_W)'($urandom_range(0, 127));
      write_vertex_count(setting);
      if (phase == 2) hold_output = 1'b1;
      n = board.vertices_in_use();
      // check the graph left over from the previous count first
      offer_item(ucd_pkg::OP_CHECK, $urandom_range(0, 63), $urandom_range(0, 63));
      repeat (5) begin
        source_quiet = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
          0: overflow_degree(n);
          1, 2: random_noise();
          default: grow_forest(n);
        endcase
      end
      phase++;
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.awaited_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
